// ===== src/ira_pkg.sv =====
// Shared types and constants for the integer reduction ALU.
// No dependencies; every other file in src imports this package.
package ira_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned OpW     = 4;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned StepW   = $clog2(DataW);

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] RegOperation    = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegInitialValue = CfgIdxW'(1);

  typedef enum logic [OpW-1:0] {
    OpAdd  = 4'd0,
    OpSub  = 4'd1,
    OpMul  = 4'd2,
    OpDiv  = 4'd3,
    OpMod  = 4'd4,
    OpAnd  = 4'd5,
    OpOr   = 4'd6,
    OpXor  = 4'd7,
    OpShl  = 4'd8,
    OpShr  = 4'd9,
    OpMax  = 4'd10,
    OpMin  = 4'd11,
    OpCond = 4'd12
  } ira_op_e;

  typedef enum logic {
    IterMul = 1'b0,
    IterDiv = 1'b1
  } ira_iter_mode_e;

  // Request into the shared iterative unit.
  typedef struct packed {
    logic           start;
    ira_iter_mode_e mode;
    logic [DataW-1:0] opa;  // multiplicand or dividend magnitude
    logic [DataW-1:0] opb;  // multiplier or divisor magnitude
  } ira_iter_req_t;

  // Response from the shared iterative unit.
  typedef struct packed {
    logic             done;
    logic [DataW-1:0] lo;   // product or remainder
    logic [DataW-1:0] quo;  // quotient
  } ira_iter_rsp_t;

endpackage

// ===== src/ira_if.sv =====
// Handshake channel interfaces: input word, result word, configuration write.
// Depends on ira_pkg for widths.
interface ira_in_if;
  import ira_pkg::*;
  logic             valid;
  logic             ready;
  logic [DataW-1:0] value;
  logic             last;
  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface ira_out_if;
  import ira_pkg::*;
  logic             valid;
  logic             ready;
  logic [DataW-1:0] reduced;
  modport source (output valid, output reduced, input ready);
  modport sink   (input valid, input reduced, output ready);
endinterface

interface ira_cfg_if;
  import ira_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [DataW-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/ira_cfg_regs.sv =====
// Configuration register file: operation and initial value.
// Depends on ira_pkg and ira_if.
module ira_cfg_regs (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  ira_cfg_if.sink                  cfg_i,
  output ira_pkg::ira_op_e         op_o,
  output logic [ira_pkg::DataW-1:0] init_o
);
  import ira_pkg::*;

  logic [OpW-1:0]   op_q, op_d;
  logic [DataW-1:0] init_q, init_d;

  assign cfg_i.ready = 1'b1;
  assign op_o        = ira_op_e'(op_q);
  assign init_o      = init_q;

  always_comb begin
    op_d   = op_q;
    init_d = init_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        RegOperation:    op_d   = cfg_i.data[OpW-1:0];
        RegInitialValue: init_d = cfg_i.data;
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q   <= '0;
      init_q <= '0;
    end else begin
      op_q   <= op_d;
      init_q <= init_d;
    end
  end

endmodule

// ===== src/ira_iter_unit.sv =====
// Shared iterative unit: one 33-bit add/subtract used for shift-add multiply
// and restoring divide, one bit per cycle. Depends on ira_pkg.
module ira_iter_unit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ira_pkg::ira_iter_req_t req_i,
  output ira_pkg::ira_iter_rsp_t rsp_o
);
  import ira_pkg::*;

  logic [DataW-1:0] acc_q, acc_d;   // product / partial remainder
  logic [DataW-1:0] sh_q, sh_d;     // multiplicand / dividend -> quotient
  logic [DataW-1:0] opb_q, opb_d;   // multiplier / divisor
  ira_iter_mode_e   mode_q, mode_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  logic [DataW:0]   x_w, y_w;
  logic             sub_w;
  logic [DataW+1:0] sum_w;
  logic             no_borrow_w;

  // the one adder
  always_comb begin
    sub_w = (mode_q == IterDiv);
    if (sub_w) begin
      x_w = {acc_q, sh_q[DataW-1]};
      y_w = {1'b0, opb_q};
    end else begin
      x_w = {1'b0, acc_q};
      y_w = {1'b0, sh_q};
    end
    sum_w = {1'b0, x_w} + {1'b0, y_w ^ {(DataW+1){sub_w}}} + {{(DataW+1){1'b0}}, sub_w};
    no_borrow_w = sum_w[DataW+1];
  end

  always_comb begin
    acc_d  = acc_q;
    sh_d   = sh_q;
    opb_d  = opb_q;
    mode_d = mode_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      acc_d  = '0;
      sh_d   = req_i.opa;
      opb_d  = req_i.opb;
      mode_d = req_i.mode;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (mode_q == IterDiv) begin
        if (no_borrow_w) begin
          acc_d = sum_w[DataW-1:0];
          sh_d  = {sh_q[DataW-2:0], 1'b1};
        end else begin
          acc_d = x_w[DataW-1:0];
          sh_d  = {sh_q[DataW-2:0], 1'b0};
        end
      end else begin
        if (opb_q[0]) acc_d = sum_w[DataW-1:0];
        sh_d  = {sh_q[DataW-2:0], 1'b0};
        opb_d = {1'b0, opb_q[DataW-1:1]};
      end
      cnt_d = cnt_q + StepW'(1);
      if (cnt_q == StepW'(DataW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      mode_q <= IterMul;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      mode_q <= mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    sh_q  <= sh_d;
    opb_q <= opb_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.lo   = acc_q;
  assign rsp_o.quo  = sh_q;

endmodule

// ===== src/integer_reduction_alu.sv =====
// Integer reduction ALU: folds signed 32-bit words into an accumulator.
// Throughput: add, sub, logic, shift, max, min, cond and divide by
// zero take one word per cycle; mul, div and mod hold off the next word until
// the 32 one-bit steps of the shared add/subtract unit plus load and commit end.
// A result word is registered; input stalls while an undrained result waits.
// Reset (rst_ni low, async) clears accumulator, in-progress flag and registers.
module integer_reduction_alu (
  input  logic     clk_i,
  input  logic     rst_ni,
  ira_cfg_if.sink  cfg_i,
  ira_in_if.sink   in_i,
  ira_out_if.source out_o
);
  import ira_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StBusy,   // waiting on the iterative unit
    StHold    // final word ready but result register still full
  } state_e;

  state_e           state_q, state_d;
  logic [DataW-1:0] acc_q, acc_d;
  logic             in_prog_q, in_prog_d;
  logic             last_q, last_d;      // last flag of the word in flight
  ira_op_e          item_op_q, item_op_d;
  logic             neg_q, neg_d;        // negate the unit's result
  logic             out_valid_q, out_valid_d;
  logic [DataW-1:0] out_data_q, out_data_d;

  ira_op_e          cfg_op;
  logic [DataW-1:0] cfg_init;

  logic             out_free;
  logic             accept;
  logic [DataW-1:0] start_val;
  logic [DataW-1:0] simple_res;
  logic             use_iter;
  logic [DataW-1:0] iter_res;
  ira_iter_req_t    iter_req;
  ira_iter_rsp_t    iter_rsp;

  ira_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .op_o   (cfg_op),
    .init_o (cfg_init)
  );

  ira_iter_unit u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (iter_req),
    .rsp_o  (iter_rsp)
  );

  // Result register frees up in the same cycle it is drained.
  assign out_free      = !out_valid_q || out_o.ready;
  assign in_i.ready    = (state_q == StIdle) && out_free;
  assign accept        = in_i.valid && in_i.ready;
  assign out_o.valid   = out_valid_q;
  assign out_o.reduced = out_data_q;

  // A new reduction folds into the initial value.
  assign start_val = in_prog_q ? acc_q : cfg_init;

  // Operations done without the iterative unit; divide/modulo by zero and unused codes keep start.
  always_comb begin
    case (cfg_op)
      OpAdd:  simple_res = start_val + in_i.value;
      OpSub:  simple_res = start_val - in_i.value;
      OpAnd:  simple_res = start_val & in_i.value;
      OpOr:   simple_res = start_val | in_i.value;
      OpXor:  simple_res = start_val ^ in_i.value;
      OpShl:  simple_res = start_val << in_i.value[4:0];
      OpShr:  simple_res = DataW'($signed(start_val) >>> in_i.value[4:0]);
      OpMax:  simple_res = ($signed(start_val) > $signed(in_i.value)) ? start_val
                                                                      : in_i.value;
      OpMin:  simple_res = ($signed(in_i.value) > $signed(start_val)) ? start_val
                                                                      : in_i.value;
      OpCond: simple_res = (in_i.value != '0) ? in_i.value : start_val;
      default: simple_res = start_val;
    endcase
  end

  // Multiply always iterates; divide and modulo only with a nonzero divisor.
  always_comb begin
    use_iter = 1'b0;
    case (cfg_op) inside
      OpMul:        use_iter = 1'b1;
      OpDiv, OpMod: use_iter = (in_i.value != '0);
      default:      use_iter = 1'b0;
    endcase
  end

  // Load the unit: raw operands for multiply, magnitudes for divide.
  always_comb begin
    iter_req.start = accept && use_iter;
    iter_req.mode  = (cfg_op == OpMul) ? IterMul : IterDiv;
    if (cfg_op == OpMul) begin
      iter_req.opa = start_val;
      iter_req.opb = in_i.value;
    end else begin
      iter_req.opa = start_val[DataW-1] ? (~start_val + DataW'(1)) : start_val;
      iter_req.opb = in_i.value[DataW-1] ? (~in_i.value + DataW'(1)) : in_i.value;
    end
  end

  // Sign fix-up: quotient truncates to zero, remainder follows the dividend.
  always_comb begin
    case (item_op_q)
      OpDiv:   iter_res = neg_q ? (~iter_rsp.quo + DataW'(1)) : iter_rsp.quo;
      OpMod:   iter_res = neg_q ? (~iter_rsp.lo + DataW'(1)) : iter_rsp.lo;
      default: iter_res = iter_rsp.lo;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    in_prog_d   = in_prog_q;
    last_d      = last_q;
    item_op_d   = item_op_q;
    neg_d       = neg_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    if (out_valid_q && out_o.ready) out_valid_d = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (use_iter) begin
            state_d   = StBusy;
            item_op_d = cfg_op;
            last_d    = in_i.last;
            neg_d     = (cfg_op == OpDiv) ? (start_val[DataW-1] ^ in_i.value[DataW-1])
                                          : start_val[DataW-1];
          end else begin
            acc_d     = simple_res;
            in_prog_d = !in_i.last;
            if (in_i.last) begin
              out_valid_d = 1'b1;
              out_data_d  = simple_res;
            end
          end
        end
      end
      StBusy: begin
        if (iter_rsp.done) begin
          acc_d     = iter_res;
          in_prog_d = !last_q;
          if (!last_q) begin
            state_d = StIdle;
          end else if (out_free) begin
            state_d     = StIdle;
            out_valid_d = 1'b1;
            out_data_d  = iter_res;
          end else begin
            state_d = StHold;
          end
        end
      end
      StHold: begin
        if (out_free) begin
          state_d     = StIdle;
          out_valid_d = 1'b1;
          out_data_d  = acc_q;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      acc_q       <= '0;
      in_prog_q   <= 1'b0;
      last_q      <= 1'b0;
      item_op_q   <= OpAdd;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      in_prog_q   <= in_prog_d;
      last_q      <= last_d;
      item_op_q   <= item_op_d;
      neg_q       <= neg_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

endmodule
